FILE: rtl/core/esc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants for the epoch to calendar converter
// Command and status words between the controller and the datapath, plus the
// phase count of the constant divisions.
// ----------------------------------------------------------------------------
package esc_pkg;

  // Field widths
  localparam int EPOCH_W = 32;
  localparam int TZ_W    = 5;
  localparam int STEP_W  = 2;

  // First phase of each constant division (counts down to zero):
  // multiply by the reciprocal, take the quotient, subtract for the remainder
  localparam logic [STEP_W-1:0] DIV_STEP_FIRST = 2'd2;

  // Datapath operations
  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL,
    DP_QUO,
    DP_REM,
    DP_YEAR,
    DP_MONTH,
    DP_PUBLISH
  } dp_op_t;

  // Divisor selection for the shared divider
  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN
  } div_sel_t;

  typedef struct packed {
    dp_op_t   op;
    div_sel_t sel;
    logic     first;
  } esc_cmd_t;

  typedef struct packed {
    logic neg;
    logic year_done;
    logic month_done;
  } esc_sts_t;

endpackage

FILE: rtl/core/epoch_seconds_to_calendar_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit: seconds since 1970 to local calendar time
// Top level: joins the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 UTC,
// shifted by the signed whole-hour offset in the configuration register
// (reset value +3), into second, minute, hour, day of month, month (0 is
// January), year, weekday (0 is Sunday) and zero-based day of year. A shifted
// time before the epoch returns out_valid_res low with every field zero. The
// unit takes one word at a time and works through the day, hour and minute
// divisions (multiply by a fixed-point reciprocal, take the quotient,
// subtract for the remainder) and then the year and month walks, one year or
// month per cycle. A time before the epoch skips the divisions and walks. A
// finished result sits in an output register, so the next word is accepted
// while it waits to be taken.
module epoch_seconds_to_calendar_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic signed [esc_pkg::TZ_W-1:0] cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [esc_pkg::EPOCH_W-1:0]     in_epoch_seconds,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_valid_res,
  output logic [5:0]                      out_second,
  output logic [5:0]                      out_minute,
  output logic [4:0]                      out_hour,
  output logic [4:0]                      out_day_of_month,
  output logic [3:0]                      out_month,
  output logic [11:0]                     out_year,
  output logic [2:0]                      out_weekday,
  output logic [8:0]                      out_day_of_year
);
  import esc_pkg::*;

  esc_cmd_t cmd;
  esc_sts_t sts;

  // Sequence the conversion
  esc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Compute and hold the result fields
  esc_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_epoch_seconds (in_epoch_seconds),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid_res    (out_valid_res),
    .out_second       (out_second),
    .out_minute       (out_minute),
    .out_hour         (out_hour),
    .out_day_of_month (out_day_of_month),
    .out_month        (out_month),
    .out_year         (out_year),
    .out_weekday      (out_weekday),
    .out_day_of_year  (out_day_of_year)
  );

endmodule

FILE: rtl/core/esc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_datapath: arithmetic and storage of the epoch to calendar converter
// Holds the timezone register, a shared reciprocal-multiply divider, the year
// and month walkers with weekday tracking, and the result registers.
// ----------------------------------------------------------------------------
module esc_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic signed [esc_pkg::TZ_W-1:0] cfg_wr_data,
  input  logic [esc_pkg::EPOCH_W-1:0]     in_epoch_seconds,
  input  esc_pkg::esc_cmd_t               cmd,
  output esc_pkg::esc_sts_t               sts,
  output logic                            out_valid_res,
  output logic [5:0]                      out_second,
  output logic [5:0]                      out_minute,
  output logic [4:0]                      out_hour,
  output logic [4:0]                      out_day_of_month,
  output logic [3:0]                      out_month,
  output logic [11:0]                     out_year,
  output logic [2:0]                      out_weekday,
  output logic [8:0]                      out_day_of_year
);
  import esc_pkg::*;

  localparam logic signed [TZ_W-1:0] TZ_RESET     = 5'sd3;
  localparam logic [11:0]            EPOCH_YEAR   = 12'd1970;
  localparam logic [2:0]             EPOCH_WDAY   = 3'd4;   // Thursday
  localparam logic [3:0]             LAST_MONTH   = 4'd11;
  localparam logic [3:0]             FEBRUARY     = 4'd1;
  localparam logic [4:0]             DAYS_FEB     = 5'd28;
  localparam logic [16:0]            SECS_DAY     = 17'd86400;
  localparam logic [16:0]            SECS_HOUR    = 17'd3600;
  localparam logic [16:0]            SECS_MIN     = 17'd60;
  // Reciprocals 2**k / d rounded up, exact over the operand ranges used:
  // days = (secs >> 7) / 675 with k = 36, hours = (rem >> 4) / 225 with
  // k = 21, minutes = (rem >> 2) / 15 with k = 14
  localparam logic [26:0]            RECIP_DAY    = 27'd101806633;
  localparam logic [26:0]            RECIP_HOUR   = 27'd9321;
  localparam logic [26:0]            RECIP_MIN    = 27'd1093;
  localparam logic [4:0]             MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Gregorian leap test over the reachable years 1970..2106: the only
  // century in that span is 2000, a multiple of 400, and 2100 which is not.
  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != 12'd2100);
  endfunction

  // Residue mod 7 of a 5-bit value
  function automatic logic [2:0] mod7_5b(input logic [4:0] v);
    logic [4:0] r;
    priority if (v >= 5'd28) r = v - 5'd28;
    else if (v >= 5'd21)     r = v - 5'd21;
    else if (v >= 5'd14)     r = v - 5'd14;
    else if (v >= 5'd7)      r = v - 5'd7;
    else                     r = v;
    return r[2:0];
  endfunction

  // Weekday plus a small advance, wrapped once
  function automatic logic [2:0] wd_add(input logic [2:0] wd, input logic [2:0] inc);
    logic [3:0] s;
    s = {1'b0, wd} + {1'b0, inc};
    if (s >= 4'd7) s = s - 4'd7;
    return s[2:0];
  endfunction

  logic signed [TZ_W-1:0] tz_r;
  logic                   neg_r;
  logic [32:0]            num_r;
  logic [52:0]            prod_r;
  logic [15:0]            quo_r;
  logic [15:0]            days_r;
  logic [11:0]            year_r;
  logic [3:0]             mon_r;
  logic [2:0]             wd_r;
  logic [8:0]             doy_r;
  logic [4:0]             hour_r;
  logic [5:0]             min_r;
  logic [5:0]             sec_r;

  logic signed [17:0] tz_secs;
  logic signed [33:0] local_secs;
  logic [25:0]        mul_a;
  logic [26:0]        mul_b;
  logic [16:0]        divisor;
  logic [15:0]        quo_sel;
  logic [52:0]        prod;
  logic [32:0]        qmul;
  logic               leap;
  logic [8:0]         ylen;
  logic [4:0]         mlen;
  logic [2:0]         wd_final;

  // Shift the input by the zone offset
  assign tz_secs    = 18'(tz_r) * 18'sd3600;
  assign local_secs = 34'(signed'({1'b0, in_epoch_seconds})) + 34'(tz_secs);

  // Pick operand, reciprocal, divisor and quotient bits for this division
  always_comb begin
    unique case (cmd.sel)
      DIV_DAY: begin
        mul_a   = num_r[32:7];
        mul_b   = RECIP_DAY;
        divisor = SECS_DAY;
        quo_sel = prod_r[51:36];
      end
      DIV_HOUR: begin
        mul_a   = 26'(num_r[16:4]);
        mul_b   = RECIP_HOUR;
        divisor = SECS_HOUR;
        quo_sel = {11'd0, prod_r[25:21]};
      end
      DIV_MIN: begin
        mul_a   = 26'(num_r[11:2]);
        mul_b   = RECIP_MIN;
        divisor = SECS_MIN;
        quo_sel = {10'd0, prod_r[19:14]};
      end
      default: begin
        mul_a   = 26'(num_r[11:2]);
        mul_b   = RECIP_MIN;
        divisor = SECS_MIN;
        quo_sel = {10'd0, prod_r[19:14]};
      end
    endcase
  end
  assign prod = 53'(mul_a) * 53'(mul_b);
  assign qmul = 33'(quo_r) * 33'(divisor);

  // Year and month lengths
  assign leap = is_leap(year_r);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = (mon_r == FEBRUARY && leap) ? 5'd29 : MONTH_LEN[mon_r];

  assign sts.neg        = neg_r;
  assign sts.year_done  = (days_r < 16'(ylen));
  assign sts.month_done = (mon_r == LAST_MONTH) || (days_r < 16'(mlen));

  assign wd_final = wd_add(wd_r, mod7_5b(days_r[4:0]));

  // Hold the timezone register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tz_r <= TZ_RESET;
    end else if (cfg_wr_en) begin
      tz_r <= cfg_wr_data;
    end
  end

  // Advance the working registers as commanded
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        neg_r  <= local_secs[33];
        num_r  <= local_secs[32:0];
        year_r <= EPOCH_YEAR;
        mon_r  <= 4'd0;
        wd_r   <= EPOCH_WDAY;
      end
      DP_MUL: begin
        prod_r <= prod;
      end
      DP_QUO: begin
        quo_r <= quo_sel;
      end
      DP_REM: begin
        num_r <= num_r - qmul;
        if (cmd.sel == DIV_DAY) begin
          days_r <= quo_r;
        end
        if (cmd.sel == DIV_HOUR) begin
          hour_r <= quo_r[4:0];
        end
      end
      DP_YEAR: begin
        if (cmd.first) begin
          min_r <= quo_r[5:0];
          sec_r <= num_r[5:0];
        end
        if (sts.year_done) begin
          doy_r <= days_r[8:0];
        end else begin
          days_r <= days_r - 16'(ylen);
          year_r <= year_r + 12'd1;
          wd_r   <= wd_add(wd_r, leap ? 3'd2 : 3'd1);
        end
      end
      DP_MONTH: begin
        if (!sts.month_done) begin
          days_r <= days_r - 16'(mlen);
          mon_r  <= mon_r + 4'd1;
          wd_r   <= wd_add(wd_r, 3'(mlen - DAYS_FEB));
        end
      end
      DP_NOP, DP_PUBLISH: begin
      end
      default: begin
      end
    endcase
  end

  // Drive the result word; a time before the epoch gives all zeros
  always_ff @(posedge clk) begin
    if (cmd.op == DP_PUBLISH) begin
      if (neg_r) begin
        out_valid_res    <= 1'b0;
        out_second       <= '0;
        out_minute       <= '0;
        out_hour         <= '0;
        out_day_of_month <= '0;
        out_month        <= '0;
        out_year         <= '0;
        out_weekday      <= '0;
        out_day_of_year  <= '0;
      end else begin
        out_valid_res    <= 1'b1;
        out_second       <= sec_r;
        out_minute       <= min_r;
        out_hour         <= hour_r;
        out_day_of_month <= days_r[4:0] + 5'd1;
        out_month        <= mon_r;
        out_year         <= year_r;
        out_weekday      <= wd_final;
        out_day_of_year  <= doy_r;
      end
    end
  end

endmodule

FILE: rtl/core/esc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_ctrl: sequencer of the epoch to calendar converter
// Steps the datapath through load, three divisions, the year and month walks
// and the result handoff, and owns both channel handshakes.
// ----------------------------------------------------------------------------
module esc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  esc_pkg::esc_sts_t sts,
  output esc_pkg::esc_cmd_t cmd
);
  import esc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DAY,
    S_HOUR,
    S_MIN,
    S_YEAR,
    S_MONTH,
    S_FINISH
  } state_t;

  state_t            state_r;
  logic [STEP_W-1:0] step_r;
  logic              first_r;
  logic              out_valid_r;
  logic              publish;
  dp_op_t            div_op;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign publish   = (state_r == S_FINISH) && (!out_valid_r || out_ready);

  // Map the division phase to its datapath operation
  assign div_op = (step_r == DIV_STEP_FIRST) ? DP_MUL :
                  (step_r == '0)             ? DP_REM : DP_QUO;

  // Decode the datapath command from the state
  always_comb begin
    cmd.op    = DP_NOP;
    cmd.sel   = DIV_DAY;
    cmd.first = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) cmd.op = DP_LOAD;
      end
      S_DAY: begin
        if (!sts.neg) cmd.op = div_op;
      end
      S_HOUR: begin
        cmd.op  = div_op;
        cmd.sel = DIV_HOUR;
      end
      S_MIN: begin
        cmd.op  = div_op;
        cmd.sel = DIV_MIN;
      end
      S_YEAR: begin
        cmd.op    = DP_YEAR;
        cmd.first = first_r;
      end
      S_MONTH: begin
        cmd.op = DP_MONTH;
      end
      S_FINISH: begin
        if (publish) cmd.op = DP_PUBLISH;
      end
      default: begin
      end
    endcase
  end

  // Hold state, step count and the output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_DAY;
            step_r  <= DIV_STEP_FIRST;
          end
        end
        S_DAY: begin
          if (sts.neg) begin
            state_r <= S_FINISH;
          end else if (step_r == '0) begin
            state_r <= S_HOUR;
            step_r  <= DIV_STEP_FIRST;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        S_HOUR: begin
          if (step_r == '0) begin
            state_r <= S_MIN;
            step_r  <= DIV_STEP_FIRST;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        S_MIN: begin
          if (step_r == '0) begin
            state_r <= S_YEAR;
            first_r <= 1'b1;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        S_YEAR: begin
          first_r <= 1'b0;
          if (sts.year_done) state_r <= S_MONTH;
        end
        S_MONTH: begin
          if (sts.month_done) state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (publish) state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: verif/calendar_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_check_pkg: expected-value side of the calendar converter bench
// Holds the broken-down time record, a behavioral conversion from shifted
// epoch seconds to local calendar time, and a scoreboard that queues the
// expected calendar words and compares them against the unit's results.
// ----------------------------------------------------------------------------
package calendar_check_pkg;

  typedef struct packed {
    logic        valid_res;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [11:0] year;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
  } calendar_t;

  // Gregorian rule: every 4th year, except centuries not divisible by 400
  function automatic bit is_leap_year(int yr);
    if (yr % 4 != 0) return 1'b0;
    if (yr % 100 != 0) return 1'b1;
    return (yr % 400 == 0);
  endfunction

  // Convert seconds since the epoch plus a whole-hour offset to local time
  function automatic calendar_t localize_epoch(logic [esc_pkg::EPOCH_W-1:0] secs,
                                               logic signed [esc_pkg::TZ_W-1:0] tz);
    int        days_in_month [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    longint    shifted_s;
    longint    day_count;
    longint    sec_of_day;
    int        yr;
    int        mon;
    int        span;
    calendar_t cal;
    cal = '0;
    shifted_s = longint'(secs);
    shifted_s = shifted_s + longint'(tz) * 3600;
    // Drop to an all-zero invalid word before the epoch
    if (shifted_s < 0) return cal;
    day_count  = shifted_s / 86400;
    sec_of_day = shifted_s % 86400;
    cal.valid_res = 1'b1;
    cal.second    = 6'(sec_of_day % 60);
    cal.minute    = 6'((sec_of_day / 60) % 60);
    cal.hour      = 5'(sec_of_day / 3600);
    // Jan 1 1970 was a Thursday
    cal.weekday   = 3'((day_count + 4) % 7);
    // Walk whole years
    yr = 1970;
    forever begin
      span = is_leap_year(yr) ? 366 : 365;
      if (day_count < span) break;
      day_count -= span;
      yr++;
    end
    cal.day_of_year = 9'(day_count);
    // Walk months; December takes whatever is left
    mon = 0;
    while (mon < 11) begin
      span = days_in_month[mon];
      if (mon == 1 && is_leap_year(yr)) span = 29;
      if (day_count < span) break;
      day_count -= span;
      mon++;
    end
    cal.day_of_month = 5'(day_count + 1);
    cal.month        = 4'(mon);
    cal.year         = 12'(yr);
    return cal;
  endfunction

  class calendar_scoreboard;
    calendar_t expected_q[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    // Queue the expected calendar word for an accepted seconds word
    function void note_word(logic [esc_pkg::EPOCH_W-1:0] secs,
                            logic signed [esc_pkg::TZ_W-1:0] tz);
      expected_q.push_back(localize_epoch(secs, tz));
    endfunction

    function void compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compare a result word against the oldest expectation
    function void check_word(calendar_t got);
      calendar_t exp_c;
      if (expected_q.size() == 0) begin
        $error("result word with no expectation waiting");
        errors++;
        return;
      end
      exp_c = expected_q.pop_front();
      compare_field("valid_res", int'(exp_c.valid_res), int'(got.valid_res));
      compare_field("second", int'(exp_c.second), int'(got.second));
      compare_field("minute", int'(exp_c.minute), int'(got.minute));
      compare_field("hour", int'(exp_c.hour), int'(got.hour));
      compare_field("day_of_month", int'(exp_c.day_of_month), int'(got.day_of_month));
      compare_field("month", int'(exp_c.month), int'(got.month));
      compare_field("year", int'(exp_c.year), int'(got.year));
      compare_field("weekday", int'(exp_c.weekday), int'(got.weekday));
      compare_field("day_of_year", int'(exp_c.day_of_year), int'(got.day_of_year));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for epoch_seconds_to_calendar_unit
// Drives seconds words through the valid/ready input, checks every calendar
// word on the output against a behavioral conversion, and sweeps the timezone
// register across its full 5-bit range, including the extremes, with random
// sender gaps and receiver stalls in several phases.
// ----------------------------------------------------------------------------
module tb;
  import calendar_check_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int LIMIT_CYCLES = 2500000;
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASE_WORDS  = 500;
  localparam int CFG_EVERY    = 125;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 cfg_wr_en;
  logic signed [esc_pkg::TZ_W-1:0]      cfg_wr_data;
  logic                                 in_valid;
  logic                                 in_ready;
  logic [esc_pkg::EPOCH_W-1:0]          in_epoch_seconds;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic                                 out_valid_res;
  logic [5:0]                           out_second;
  logic [5:0]                           out_minute;
  logic [4:0]                           out_hour;
  logic [4:0]                           out_day_of_month;
  logic [3:0]                           out_month;
  logic [11:0]                          out_year;
  logic [2:0]                           out_weekday;
  logic [8:0]                           out_day_of_year;

  logic signed [esc_pkg::TZ_W-1:0]      tz_shadow = 5'sd3;
  int                                   idle_pct  = 0;
  int                                   stall_pct = 0;
  int                                   cycle_count = 0;
  calendar_scoreboard                   sb = new();

  epoch_seconds_to_calendar_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_valid_res    (out_valid_res),
    .out_second       (out_second),
    .out_minute       (out_minute),
    .out_hour         (out_hour),
    .out_day_of_month (out_day_of_month),
    .out_month        (out_month),
    .out_year         (out_year),
    .out_weekday      (out_weekday),
    .out_day_of_year  (out_day_of_year)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Stall the receiver at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Note each accepted seconds word with the offset in force
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_word(in_epoch_seconds, tz_shadow);
    end
  end

  // Check each accepted calendar word
  always @(posedge clk) begin
    calendar_t got;
    if (rst_n && out_valid && out_ready) begin
      got.valid_res    = out_valid_res;
      got.second       = out_second;
      got.minute       = out_minute;
      got.hour         = out_hour;
      got.day_of_month = out_day_of_month;
      got.month        = out_month;
      got.year         = out_year;
      got.weekday      = out_weekday;
      got.day_of_year  = out_day_of_year;
      sb.check_word(got);
    end
  end

  // Offer one word after a random gap; hold it until accepted
  task automatic send_word(logic [esc_pkg::EPOCH_W-1:0] secs);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_epoch_seconds <= secs;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold off the sender until every expected word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Write the offset register; only called with the unit idle
  task automatic write_offset(logic signed [esc_pkg::TZ_W-1:0] tz);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= tz;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tz_shadow    = tz;
  endtask

  // Mix full-range words with words near the epoch, the top of the range
  // and day boundaries
  function automatic logic [esc_pkg::EPOCH_W-1:0] pick_seconds();
    logic [esc_pkg::EPOCH_W-1:0] day_base;
    day_base = $urandom_range(49709) * 86400;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return $urandom;
      6:                return $urandom_range(120000);
      7:                return $urandom_range(32'hFFFFFFFF, 32'hFFF00000);
      8:                return day_base + $urandom_range(1) * 86399;
      default:          return day_base - 1;
    endcase
  endfunction

  // Stimulus
  initial begin
    static int idle_by_phase  [4] = '{0, 75, 0, 30};
    static int stall_by_phase [4] = '{0, 0, 75, 30};
    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    in_valid         <= 1'b0;
    in_epoch_seconds <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset offset of +3: range ends and leap-year corners
    send_word(32'd0);
    send_word(32'hFFFFFFFF);
    send_word(32'd68169600);
    send_word(32'd951782400);
    send_word(32'd4107542400);
    send_word(32'd1104451200);
    send_word(32'd10799);

    // Most negative offset: just before and exactly at the epoch
    write_offset(-5'sd16);
    send_word(32'd0);
    send_word(32'd57599);
    send_word(32'd57600);
    send_word(32'hFFFFFFFF);

    // Most positive offset: push past the top of the 32-bit count
    write_offset(5'sd15);
    send_word(32'd0);
    send_word(32'hFFFFFFFF);
    send_word(32'd4107488400);

    // Negative hours wrap back into the previous day
    write_offset(-5'sd12);
    send_word(32'd43199);
    send_word(32'd43200);
    send_word(32'd951782400);

    write_offset(5'sd14);
    send_word(32'hFFFFFFFF);
    send_word(32'd31485599);

    // Zero offset: day and century boundaries
    write_offset(5'sd0);
    send_word(32'd86399);
    send_word(32'd946684800);
    send_word(32'd4102444800);
    send_word(32'd4102444799);

    // Random phases with different gap and stall pressure
    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n % CFG_EVERY == 0) begin
          write_offset(5'($urandom_range(31)));
          idle_pct  = idle_by_phase[ph];
          stall_pct = stall_by_phase[ph];
        end
        send_word(pick_seconds());
      end
    end

    // Wait out the last results, then report
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (sb.pending() != 0) $error("%0d expected words never arrived", sb.pending());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
